### hdl/cwt_pkg.sv
package cwt_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 16;
  localparam int HW_W        = 7;
  localparam int POS_W       = 32;
  localparam int THR_W       = 32;
  localparam int Q_FRAC      = 8;

  localparam logic [HW_W-1:0]   HALF_WINDOW_RESET = 7'd8;
  localparam logic [GAIN_W-1:0] GAIN_RESET        = 16'd384;

  // APB register map: register index sits in paddr[2]
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_HALF_WINDOW    = 1'b0;
  localparam logic REG_THRESHOLD_GAIN = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] energy_value;
    logic                   stream_end;
  } cwt_in_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold_value;
    logic [POS_W-1:0] position_index;
    logic             run_last;
  } cwt_out_t;

endpackage

### hdl/cwt_ram.sv
module cwt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/centered_window_threshold_core.sv
// Centered-window adaptive threshold.
// Input channel (in_valid/in_ready/in_data) takes one energy sample per beat;
// stream_end marks the last sample of a stream. Output channel
// (out_valid/out_ready/out_data) gives gain * floor(window mean) >> 8 for each
// stream position, with its position index; run_last flags the final result
// caused by one input beat. Configuration goes through the APB port:
// half_window at 0x0, threshold_gain at 0x4 (pready tied high).
// Timing: one sample at a time. A non-final sample passes from acceptance to
// its result being loaded into the output register through update, a radix-2
// divider, multiply and load; no new sample is taken until then. The
// final sample flushes up to W results, each after trimming the values
// that leave the window sum; the shared restoring divider sets the pace.
// Results lag the input by W-1 positions. The sample ring sits in a
// registered-read RAM; the core only uses ring entries after they are written.
// Reset clears all stream state and loads the register defaults; no clearing
// pass is needed. A stalled receiver holds the output register; the core waits
// for it to drain before loading the next result, and a new sample can be
// accepted while the last result still waits.
module centered_window_threshold_core #(
  parameter int MAX_HALF_WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cwt_pkg::cwt_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cwt_pkg::cwt_out_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cwt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cwt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cwt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import cwt_pkg::*;

  localparam int RING       = 2 * MAX_HALF_WINDOW;
  localparam int PTR_W      = $clog2(RING);
  localparam int CNT_W      = $clog2(RING + 1);
  localparam int SUM_W      = SAMPLE_BITS + PTR_W;
  localparam int DCNT_W     = $clog2(SUM_W + 1);
  localparam int PROD_W     = SAMPLE_BITS + GAIN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_CHK, S_SUB, S_DIV, S_MUL, S_OUT
  } state_t;

  state_t                 state_r;
  logic [HW_W-1:0]        half_window_r;
  logic [GAIN_W-1:0]      gain_r;

  logic [PTR_W-1:0]       wp_r;
  logic [CNT_W-1:0]       seen_r;
  logic [SUM_W-1:0]       sum_r;
  logic [POS_W-1:0]       pos_r;
  logic [CNT_W-1:0]       w_r;

  logic [SAMPLE_BITS-1:0] val_r;
  logic                   last_r;
  logic                   drop_r;
  logic [POS_W-1:0]       p_r;
  logic [CNT_W-1:0]       j_r;
  logic [CNT_W-1:0]       dist_r;

  logic [SUM_W-1:0]       quo_r;
  logic [CNT_W-1:0]       rem_r;
  logic [CNT_W-1:0]       divisor_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic [PROD_W-1:0]      prod_r;
  logic [POS_W-1:0]       opos_r;
  logic                   olast_r;

  logic                   out_valid_r;
  cwt_out_t               out_data_r;

  logic [CNT_W-1:0]       hw_clamped;
  logic [CNT_W-1:0]       w_cur;
  logic [CNT_W-1:0]       span_cur;
  logic [CNT_W-1:0]       span_w;
  logic [PTR_W-1:0]       wp_inc;
  logic [CNT_W-1:0]       seen_new;
  logic [CNT_W-1:0]       held_new;
  logic [CNT_W-1:0]       first_j;
  logic [CNT_W-1:0]       reach;
  logic [CNT_W-1:0]       start_c;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W:0]         rem_shift;
  logic                   q_bit;
  logic [THR_W-1:0]       thr_value;
  logic                   in_fire;
  logic                   cfg_wr;

  logic                   ram_rd_en;
  logic [PTR_W-1:0]       ram_rd_addr;
  logic [SAMPLE_BITS-1:0] ram_rd_data;

  // Entry d places back from ptr, modulo ring depth (depth need not be 2^n)
  function automatic logic [PTR_W-1:0] ring_back(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] d);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(ptr) + (CNT_W+1)'(RING) - (CNT_W+1)'(d);
    if (t >= (CNT_W+1)'(RING)) begin
      t = t - (CNT_W+1)'(RING);
    end
    return PTR_W'(t);
  endfunction

  assign in_fire = in_valid && in_ready;
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    if (half_window_r == '0) begin
      hw_clamped = CNT_W'(1);
    end else if (half_window_r > HW_W'(MAX_HALF_WINDOW)) begin
      hw_clamped = CNT_W'(MAX_HALF_WINDOW);
    end else begin
      hw_clamped = CNT_W'(half_window_r);
    end
  end

  // window width is latched at the first beat of each stream
  assign w_cur    = (seen_r == '0) ? hw_clamped : w_r;
  assign span_cur = CNT_W'({w_cur, 1'b0});
  assign span_w   = CNT_W'({w_r, 1'b0});

  assign wp_inc   = (wp_r == PTR_W'(RING - 1)) ? '0 : wp_r + PTR_W'(1);
  assign seen_new = (seen_r == CNT_W'(RING)) ? seen_r : seen_r + CNT_W'(1);
  assign held_new = (seen_new < span_w) ? seen_new : span_w;
  assign first_j  = ((w_r - CNT_W'(1)) < (seen_new - CNT_W'(1))) ?
                    (w_r - CNT_W'(1)) : (seen_new - CNT_W'(1));
  assign reach    = j_r + w_r;
  assign start_c  = (reach < (seen_r - CNT_W'(1))) ? reach : (seen_r - CNT_W'(1));

  // oldest value leaves the window sum before the new one enters
  assign sum_new  = sum_r - (drop_r ? SUM_W'(ram_rd_data) : '0) + SUM_W'(val_r);

  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor_r});

  // saturation only bites if samples grow past 24 bits
  always_comb begin
    if ((prod_r >> (Q_FRAC + THR_W)) != '0) begin
      thr_value = '1;
    end else begin
      thr_value = THR_W'(prod_r >> Q_FRAC);
    end
  end

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = ring_back(wp_r, span_cur - CNT_W'(1));
    if (state_r == S_CHK) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = ring_back(wp_r, dist_r);
    end else if (in_fire) begin
      ram_rd_en   = 1'b1;
    end
  end

  cwt_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == S_UPD),
    .wr_addr (wp_inc),
    .wr_data (val_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      half_window_r <= HALF_WINDOW_RESET;
      gain_r        <= GAIN_RESET;
      wp_r          <= '0;
      seen_r        <= '0;
      sum_r         <= '0;
      pos_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_HALF_WINDOW:    half_window_r <= pwdata[HW_W-1:0];
          REG_THRESHOLD_GAIN: gain_r        <= pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      // in S_OUT a taken beat is always replaced by the next load
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (seen_r == '0) begin
              w_r <= hw_clamped;
            end
            drop_r  <= (seen_r >= span_cur);
            val_r   <= in_data.energy_value;
            last_r  <= in_data.stream_end;
            p_r     <= pos_r;
            state_r <= S_UPD;
          end
        end

        S_UPD: begin
          wp_r   <= wp_inc;
          seen_r <= seen_new;
          sum_r  <= sum_new;
          pos_r  <= pos_r + POS_W'(1);
          if (!last_r) begin
            if (seen_new >= w_r) begin
              quo_r     <= sum_new;
              rem_r     <= '0;
              divisor_r <= held_new;
              dcnt_r    <= '0;
              opos_r    <= p_r - POS_W'(w_r - CNT_W'(1));
              olast_r   <= 1'b1;
              state_r   <= S_DIV;
            end else begin
              state_r   <= S_IDLE;
            end
          end else begin
            j_r     <= first_j;
            dist_r  <= held_new - CNT_W'(1);
            state_r <= S_CHK;
          end
        end

        // flush: trim the window sum down to the positions this result covers
        S_CHK: begin
          if (dist_r > start_c) begin
            state_r <= S_SUB;
          end else begin
            quo_r     <= sum_r;
            rem_r     <= '0;
            divisor_r <= start_c + CNT_W'(1);
            dcnt_r    <= '0;
            opos_r    <= p_r - POS_W'(j_r);
            olast_r   <= (j_r == '0);
            state_r   <= S_DIV;
          end
        end

        S_SUB: begin
          sum_r   <= sum_r - SUM_W'(ram_rd_data);
          dist_r  <= dist_r - CNT_W'(1);
          state_r <= S_CHK;
        end

        S_DIV: begin
          if (q_bit) begin
            rem_r <= CNT_W'(rem_shift - {1'b0, divisor_r});
          end else begin
            rem_r <= CNT_W'(rem_shift);
          end
          quo_r  <= {quo_r[SUM_W-2:0], q_bit};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(SUM_W - 1)) begin
            state_r <= S_MUL;
          end
        end

        // mean never exceeds one sample, so the low bits carry it
        S_MUL: begin
          prod_r  <= PROD_W'(quo_r[SAMPLE_BITS-1:0]) * PROD_W'(gain_r);
          state_r <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.threshold_value <= thr_value;
            out_data_r.position_index  <= opos_r;
            out_data_r.run_last        <= olast_r;
            if (last_r && (j_r != '0)) begin
              j_r     <= j_r - CNT_W'(1);
              state_r <= S_CHK;
            end else begin
              if (last_r) begin
                wp_r   <= '0;
                seen_r <= '0;
                sum_r  <= '0;
                pos_r  <= '0;
              end
              state_r <= S_IDLE;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_HALF_WINDOW:    prdata = CFG_DATA_W'(half_window_r);
      REG_THRESHOLD_GAIN: prdata = CFG_DATA_W'(gain_r);
      default:            prdata = '0;
    endcase
  end

endmodule

### test/threshold_checker.sv
`timescale 1ns / 100ps

module threshold_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  cwt_pkg::cwt_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  cwt_pkg::cwt_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [cwt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cwt_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             mismatch_count,
  output int                             results_due
);

  import cwt_pkg::*;

  localparam int MAX_W      = 64;
  localparam int RING_DEPTH = 2 * MAX_W;

  logic [SAMPLE_BITS-1:0] energy_ring [RING_DEPTH];
  logic [HW_W-1:0]        half_w_reg;
  logic [GAIN_W-1:0]      gain_reg;
  longint unsigned        run_sum;
  int unsigned            next_pos;
  int unsigned            wr_idx;
  int unsigned            fill;
  int unsigned            run_w;
  cwt_out_t               expected_thresholds [$];

  initial mismatch_count = 0;

  function automatic logic [SAMPLE_BITS-1:0] ring_back(input int unsigned lag);
    return energy_ring[(wr_idx + RING_DEPTH - lag % RING_DEPTH) % RING_DEPTH];
  endfunction

  function automatic logic [THR_W-1:0] scale_mean(input longint unsigned total,
                                                  input int unsigned cnt);
    longint unsigned prod;
    if (cnt == 0) return '0;
    prod = ((total / cnt) * longint'(gain_reg)) >> Q_FRAC;
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    return prod[THR_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [POS_W-1:0] pos,
                                 input logic [THR_W-1:0] got,
                                 input logic [THR_W-1:0] want);
    if (mismatch_count < 100)
      $display("%0t: %s mismatch at position %0d: got %0h, expected %0h",
               $time, what, pos, got, want);
    mismatch_count++;
  endtask

  // Works out every threshold that one accepted sample releases.
  task automatic compute_thresholds(input cwt_in_t beat);
    int unsigned     w;
    int unsigned     span;
    int unsigned     p;
    int unsigned     held;
    int unsigned     j;
    int unsigned     tail;
    int unsigned     start;
    longint unsigned partial;
    cwt_out_t        res;
    if (fill == 0) begin
      if (half_w_reg == 0) run_w = 1;
      else if (half_w_reg > MAX_W) run_w = MAX_W;
      else run_w = half_w_reg;
    end
    w = run_w;
    span = 2 * w;
    p = next_pos;
    // oldest value leaves the window before its slot can be overwritten
    if (fill >= span) run_sum -= ring_back(span - 1);
    wr_idx = (wr_idx + 1) % RING_DEPTH;
    energy_ring[wr_idx] = beat.energy_value;
    run_sum += beat.energy_value;
    if (fill < RING_DEPTH) fill++;
    next_pos = p + 1;
    held = (fill < span) ? fill : span;
    if (!beat.stream_end) begin
      if (fill >= w) begin
        res.threshold_value = scale_mean(run_sum, held);
        res.position_index  = p - (w - 1);
        res.run_last        = 1'b1;
        expected_thresholds.push_back(res);
      end
    end else begin
      // flush: window tails shrink as the pending positions approach the end
      j = (w - 1 < fill - 1) ? w - 1 : fill - 1;
      partial = run_sum;
      tail = held - 1;
      forever begin
        start = (j + w < fill - 1) ? j + w : fill - 1;
        while (tail > start) begin
          partial -= ring_back(tail);
          tail--;
        end
        res.threshold_value = scale_mean(partial, start + 1);
        res.position_index  = p - j;
        res.run_last        = (j == 0);
        expected_thresholds.push_back(res);
        if (j == 0) break;
        j--;
      end
      run_sum  = 0;
      next_pos = 0;
      wr_idx   = 0;
      fill     = 0;
      run_w    = 0;
    end
  endtask

  task automatic check_result(input cwt_out_t got);
    cwt_out_t want;
    if (expected_thresholds.size() == 0) begin
      report_mismatch("unexpected beat", got.position_index, got.threshold_value, '0);
    end else begin
      want = expected_thresholds.pop_front();
      if (got.threshold_value !== want.threshold_value)
        report_mismatch("threshold_value", want.position_index,
                        got.threshold_value, want.threshold_value);
      if (got.position_index !== want.position_index)
        report_mismatch("position_index", want.position_index,
                        got.position_index, want.position_index);
      if (got.run_last !== want.run_last)
        report_mismatch("run_last", want.position_index,
                        THR_W'(got.run_last), THR_W'(want.run_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      half_w_reg = HALF_WINDOW_RESET;
      gain_reg   = GAIN_RESET;
      run_sum    = 0;
      next_pos   = 0;
      wr_idx     = 0;
      fill       = 0;
      run_w      = 0;
      expected_thresholds.delete();
      results_due <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HALF_WINDOW) half_w_reg = pwdata[HW_W-1:0];
        else gain_reg = pwdata[GAIN_W-1:0];
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) compute_thresholds(in_data);
      results_due <= expected_thresholds.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cwt_pkg::*;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cwt_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cwt_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int          mismatch_count;
  int          results_due;
  int          cycle_count = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int unsigned eff_w = 8;

  always #4 clk = ~clk;

  centered_window_threshold_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  threshold_checker threshold_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver: short random stalls, plus the long hold-off on request
  initial begin : sink_drive
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_served != hold_asks) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
        out_ready <= 1'b1;
      end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_BITS'($urandom_range(0, 255));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // valid is only lowered on a gap, so back-to-back beats keep it high
  task automatic send_beat(input logic [SAMPLE_BITS-1:0] energy, input logic fin);
    cwt_in_t beat;
    beat.energy_value = energy;
    beat.stream_end   = fin;
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits of each write carry junk, the core keeps only the field width
  task automatic set_config(input logic [HW_W-1:0] hw, input logic [GAIN_W-1:0] gain);
    logic [CFG_DATA_W-HW_W-1:0]   hw_junk;
    logic [CFG_DATA_W-GAIN_W-1:0] gain_junk;
    hw_junk   = (CFG_DATA_W-HW_W)'($urandom);
    gain_junk = (CFG_DATA_W-GAIN_W)'($urandom);
    drain();
    write_reg(REG_HALF_WINDOW, {hw_junk, hw});
    write_reg(REG_THRESHOLD_GAIN, {gain_junk, gain});
    eff_w = (hw == 0) ? 1 : (hw > 64) ? 64 : hw;
  endtask

  task automatic send_stream(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_beat(pick_energy(), i == len - 1);
  endtask

  // mix of streams no longer than W (flush only) and longer ones
  task automatic run_streams(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 1)) len = $urandom_range(1, eff_w);
      else len = $urandom_range(eff_w + 1, 3 * eff_w + 4);
      if (len > budget - sent) len = budget - sent;
      send_stream(len);
      sent += len;
      if ($urandom_range(0, 4) == 0) drain();
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone full-scale sample at reset defaults
    send_beat('1, 1'b1);

    set_config(7'd1, 16'hFFFF);
    send_beat('0, 1'b0);
    send_beat('1, 1'b0);
    send_beat(24'h800000, 1'b0);
    send_beat(24'h7FFFFF, 1'b1);

    // zero half window behaves as one
    set_config(7'd0, 16'h0000);
    send_beat(24'h123456, 1'b0);
    send_beat(24'hABCDEF, 1'b1);

    // oversize half window clamps; stream ends well short of W
    set_config(7'd127, 16'h0100);
    send_beat(24'hAAAAAA, 1'b0);
    send_beat(24'h555555, 1'b0);
    send_beat(24'hFFFFFF, 1'b1);

    // registers changed mid-stream: gain applies at once, W waits for next stream
    set_config(7'd3, 16'd384);
    repeat (4) send_beat(pick_energy(), 1'b0);
    set_config(7'd5, 16'd512);
    send_beat(pick_energy(), 1'b0);
    send_beat(pick_energy(), 1'b0);
    send_beat(pick_energy(), 1'b1);

    src_idle_pct  = 20;
    sink_idle_pct = 20;
    set_config(7'd1, 16'($urandom));
    run_streams(30);

    // widest window, long enough to saturate the sample count
    src_idle_pct  = 10;
    sink_idle_pct = 30;
    set_config(7'd64, 16'hFFFF);
    send_stream($urandom_range(130, 140));

    src_idle_pct  = 40;
    sink_idle_pct = 0;
    set_config(7'd2, 16'd1);
    run_streams(30);

    // receiver holds off while the sender keeps offering
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_config(7'd4, 16'd384);
    hold_asks <= hold_asks + 1;
    run_streams(30);

    src_idle_pct  = 30;
    sink_idle_pct = 30;
    set_config(7'($urandom_range(1, 16)), 16'($urandom));
    run_streams(35);

    src_idle_pct  = 20;
    sink_idle_pct = 20;
    set_config(7'($urandom_range(17, 64)), 16'($urandom));
    run_streams(35);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_config(7'($urandom_range(1, 12)), 16'($urandom));
    run_streams(35);

    drain();
    if (mismatch_count == 0 && results_due == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

### files.f
hdl/cwt_pkg.sv
hdl/cwt_ram.sv
hdl/centered_window_threshold_core.sv
test/threshold_checker.sv
test/tb_top.sv
